[src/sa_pkg.sv]
// Shared types, constants and saturating arithmetic helpers for the steering agent.
package sa_pkg;

    localparam int FRAC_BITS = 16;

    typedef enum logic [2:0] {
        CMD_SEEK      = 3'd0,
        CMD_FLEE      = 3'd1,
        CMD_ARRIVE    = 3'd2,
        CMD_PURSUE    = 3'd3,
        CMD_INTEGRATE = 3'd4,
        CMD_BOUNCE    = 3'd5,
        CMD_LOAD_POS  = 3'd6,
        CMD_LOAD_VEL  = 3'd7
    } t_cmd;

    localparam logic [2:0] REG_MAX_SPEED  = 3'd0;
    localparam logic [2:0] REG_MAX_FORCE  = 3'd1;
    localparam logic [2:0] REG_ARR_RADIUS = 3'd2;
    localparam logic [2:0] REG_BOX_X      = 3'd3;
    localparam logic [2:0] REG_BOX_Y      = 3'd4;
    localparam logic [2:0] REG_BOX_Z      = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOAD,
        S_SQ_MUL,
        S_SQ_ACC,
        S_LIM_MUL,
        S_LIM_CMP,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_ROUTE,
        S_AR_MUL,
        S_AR_DIV,
        S_AR_WAIT,
        S_AH_DIV,
        S_AH_WAIT,
        S_PR_MUL,
        S_PR_ACC,
        S_SC_MUL,
        S_SC_DIV,
        S_SC_WAIT,
        S_POST,
        S_OUT
    } t_state;

    localparam logic [31:0] ARRIVE_STOP = 32'(10 << FRAC_BITS);

    function automatic logic [30:0] f_fixed_int(input logic [31:0] n);
        logic [63:0] v;
        v = {32'd0, n} << FRAC_BITS;
        if (v > 64'h7FFF_FFFF) begin
            return 31'h7FFF_FFFF;
        end
        return v[30:0];
    endfunction

    function automatic logic signed [31:0] f_sat33(input logic signed [32:0] v);
        if (v > 33'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -33'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] f_add(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return f_sat33({a[31], a} + {b[31], b});
    endfunction

    function automatic logic signed [31:0] f_sub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return f_sat33({a[31], a} - {b[31], b});
    endfunction

    function automatic logic [31:0] f_mag(input logic signed [31:0] a);
        logic [32:0] t;
        t = a[31] ? -{a[31], a} : {a[31], a};
        return t[31:0];
    endfunction

    // Apply the sign to an unsigned magnitude and saturate to 32 bits.
    function automatic logic signed [31:0] f_signed(input logic [63:0] p, input logic neg);
        if (neg) begin
            if (p >= 64'h8000_0000) begin
                return 32'sh8000_0000;
            end
            return -p[31:0];
        end
        if (p >= 64'h7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end
        return p[31:0];
    endfunction

endpackage

[src/steering_agent_step.sv]
// Steering agent: sequencer, shared multiplier and agent state around divider and root units.
// Divides run on the bit-serial divider and vector lengths on the root unit.
// One word is worked at a time; input stall is high from acceptance until the result is staged.
// Synchronous active-low reset restores the configuration registers and agent state to defaults.
module steering_agent_step (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_target_x,
    input  logic [31:0] i_target_y,
    input  logic [31:0] i_target_z,
    input  logic [31:0] i_target_vel_x,
    input  logic [31:0] i_target_vel_y,
    input  logic [31:0] i_target_vel_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_out_pos_x,
    output logic [31:0] o_out_pos_y,
    output logic [31:0] o_out_pos_z,
    output logic [31:0] o_out_vel_x,
    output logic [31:0] o_out_vel_y,
    output logic [31:0] o_out_vel_z,
    output logic [31:0] o_out_force_x,
    output logic [31:0] o_out_force_y,
    output logic [31:0] o_out_force_z,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data
);
    import sa_pkg::*;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    logic   r_phase;
    logic [1:0] r_k;

    logic [30:0] r_max_speed, r_max_force, r_arr_radius;
    logic [30:0] r_box [3];

    logic signed [31:0] r_pos [3];
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_frc [3];
    logic signed [31:0] r_tgt [3];
    logic signed [31:0] r_tv  [3];
    logic signed [31:0] r_d   [3];
    logic signed [31:0] r_o_pos [3];
    logic signed [31:0] r_o_vel [3];
    logic signed [31:0] r_o_frc [3];
    logic        r_o_valid;

    logic [63:0] r_sum;
    logic [63:0] r_prod;
    logic [31:0] r_len;
    logic [31:0] r_m;

    logic [31:0] mul_a, mul_b;
    logic        div_start, div_done;
    logic [63:0] div_dividend, div_q;
    logic [31:0] div_divisor;
    logic        sq_start, sq_done;
    logic [31:0] sq_root;
    logic        in_acc, out_go;
    logic [31:0] max_speed_nz;

    assign in_acc       = i_valid && !o_stall;
    assign out_go       = !r_o_valid || !i_stall;
    assign max_speed_nz = (r_max_speed != '0) ? {1'b0, r_max_speed} : 32'd1;

    sa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    sa_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (r_sum),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = r_prod;
        div_divisor  = r_len;
        sq_start     = 1'b0;
        o_stall      = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_LOAD;
            end
            S_LOAD: begin
                case (r_cmd)
                    CMD_BOUNCE, CMD_LOAD_POS, CMD_LOAD_VEL: n_state = S_OUT;
                    default: n_state = S_SQ_MUL;
                endcase
            end
            S_SQ_MUL: begin
                mul_a   = f_mag(r_d[r_k]);
                mul_b   = f_mag(r_d[r_k]);
                n_state = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                if (r_k != 2'd2) begin
                    n_state = S_SQ_MUL;
                end else if (r_cmd == CMD_INTEGRATE) begin
                    n_state = S_LIM_MUL;
                end else begin
                    n_state = S_SQRT_GO;
                end
            end
            S_LIM_MUL: begin
                mul_a   = r_m;
                mul_b   = r_m;
                n_state = S_LIM_CMP;
            end
            S_LIM_CMP: begin
                n_state = (r_sum > r_prod) ? S_SQRT_GO : S_POST;
            end
            S_SQRT_GO: begin
                sq_start = 1'b1;
                n_state  = S_SQRT_WAIT;
            end
            S_SQRT_WAIT: begin
                if (sq_done) n_state = S_ROUTE;
            end
            S_ROUTE: begin
                case (r_cmd)
                    CMD_ARRIVE: begin
                        if (r_len <= ARRIVE_STOP) begin
                            n_state = S_OUT;
                        end else if (r_len <= {1'b0, r_arr_radius}) begin
                            n_state = S_AR_MUL;
                        end else begin
                            n_state = S_SC_MUL;
                        end
                    end
                    CMD_PURSUE: begin
                        if (!r_phase) begin
                            n_state = S_AH_DIV;
                        end else begin
                            n_state = (r_len == '0) ? S_POST : S_SC_MUL;
                        end
                    end
                    CMD_INTEGRATE: n_state = S_SC_MUL;
                    default: n_state = (r_len == '0) ? S_POST : S_SC_MUL;
                endcase
            end
            S_AR_MUL: begin
                mul_a   = {1'b0, r_max_speed};
                mul_b   = r_len;
                n_state = S_AR_DIV;
            end
            S_AR_DIV: begin
                div_start   = 1'b1;
                div_divisor = {1'b0, r_arr_radius};
                n_state     = S_AR_WAIT;
            end
            S_AR_WAIT: begin
                if (div_done) n_state = S_SC_MUL;
            end
            S_AH_DIV: begin
                div_start    = 1'b1;
                div_dividend = {32'd0, r_len} << FRAC_BITS;
                div_divisor  = max_speed_nz;
                n_state      = S_AH_WAIT;
            end
            S_AH_WAIT: begin
                if (div_done) n_state = S_PR_MUL;
            end
            S_PR_MUL: begin
                mul_a   = f_mag(r_tv[r_k]);
                mul_b   = r_m;
                n_state = S_PR_ACC;
            end
            S_PR_ACC: begin
                n_state = (r_k == 2'd2) ? S_LOAD : S_PR_MUL;
            end
            S_SC_MUL: begin
                mul_a   = f_mag(r_d[r_k]);
                mul_b   = r_m;
                n_state = S_SC_DIV;
            end
            S_SC_DIV: begin
                div_start = 1'b1;
                n_state   = S_SC_WAIT;
            end
            S_SC_WAIT: begin
                if (div_done) n_state = (r_k == 2'd2) ? S_POST : S_SC_MUL;
            end
            S_POST: begin
                if (r_cmd == CMD_INTEGRATE && !r_phase) begin
                    n_state = S_SQ_MUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_go) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and agent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed  <= f_fixed_int(32'd50);
            r_max_force  <= f_fixed_int(32'd5);
            r_arr_radius <= f_fixed_int(32'd50);
            r_box[0]     <= f_fixed_int(32'd1024);
            r_box[1]     <= f_fixed_int(32'd768);
            r_box[2]     <= f_fixed_int(32'd800);
            r_pos[0]     <= {1'b0, f_fixed_int(32'd300)};
            r_pos[1]     <= {1'b0, f_fixed_int(32'd300)};
            r_pos[2]     <= '0;
            for (int i = 0; i < 3; i++) begin
                r_vel[i] <= '0;
                r_frc[i] <= '0;
            end
            r_o_valid <= 1'b0;
            r_k       <= '0;
            r_phase   <= 1'b0;
            r_cmd     <= CMD_SEEK;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAX_SPEED:  r_max_speed  <= i_cfg_data;
                    REG_MAX_FORCE:  r_max_force  <= i_cfg_data;
                    REG_ARR_RADIUS: r_arr_radius <= i_cfg_data;
                    REG_BOX_X:      r_box[0]     <= i_cfg_data;
                    REG_BOX_Y:      r_box[1]     <= i_cfg_data;
                    REG_BOX_Z:      r_box[2]     <= i_cfg_data;
                    default: ;
                endcase
            end

            // A new word may replace the one leaving in the same cycle.
            if (r_state == S_OUT && out_go) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= t_cmd'(i_cmd);
                        r_phase <= 1'b0;
                    end
                end
                S_LOAD: begin
                    r_k <= '0;
                    for (int i = 0; i < 3; i++) begin
                        case (r_cmd)
                            CMD_BOUNCE: begin
                                if (r_pos[i] > $signed({1'b0, r_box[i]})) begin
                                    r_pos[i] <= {1'b0, r_box[i]};
                                    r_vel[i] <= f_sub(32'sd0, r_vel[i]);
                                end else if (r_pos[i] < 0) begin
                                    r_pos[i] <= '0;
                                    r_vel[i] <= f_sub(32'sd0, r_vel[i]);
                                end
                            end
                            CMD_LOAD_POS: r_pos[i] <= r_tgt[i];
                            CMD_LOAD_VEL: r_vel[i] <= r_tgt[i];
                            default: ;
                        endcase
                    end
                end
                S_SQ_ACC: r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                S_ROUTE: begin
                    r_k <= '0;
                    if (r_cmd == CMD_ARRIVE && r_len <= ARRIVE_STOP) begin
                        for (int i = 0; i < 3; i++) begin
                            r_frc[i] <= '0;
                            r_vel[i] <= '0;
                        end
                    end
                end
                S_PR_ACC: begin
                    r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                    if (r_k == 2'd2) r_phase <= 1'b1;
                end
                S_SC_WAIT: begin
                    if (div_done) r_k <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
                end
                S_POST: begin
                    r_k <= '0;
                    for (int i = 0; i < 3; i++) begin
                        case (r_cmd)
                            CMD_INTEGRATE: begin
                                if (!r_phase) begin
                                    r_frc[i] <= r_d[i];
                                    r_vel[i] <= f_add(r_vel[i], r_d[i]);
                                end else begin
                                    r_vel[i] <= r_d[i];
                                    r_pos[i] <= f_add(r_pos[i], r_d[i]);
                                end
                            end
                            CMD_FLEE: r_frc[i] <= f_sub(r_frc[i], f_sub(r_d[i], r_vel[i]));
                            default:  r_frc[i] <= f_add(r_frc[i], f_sub(r_d[i], r_vel[i]));
                        endcase
                    end
                    if (r_cmd == CMD_INTEGRATE) r_phase <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_tgt[0] <= i_target_x;
                    r_tgt[1] <= i_target_y;
                    r_tgt[2] <= i_target_z;
                    r_tv[0]  <= i_target_vel_x;
                    r_tv[1]  <= i_target_vel_y;
                    r_tv[2]  <= i_target_vel_z;
                end
            end
            S_LOAD: begin
                r_sum <= '0;
                for (int i = 0; i < 3; i++) begin
                    r_d[i] <= (r_cmd == CMD_INTEGRATE) ? r_frc[i] : f_sub(r_tgt[i], r_pos[i]);
                end
                r_m <= (r_cmd == CMD_INTEGRATE) ? {1'b0, r_max_force} : {1'b0, r_max_speed};
            end
            S_SQ_ACC: r_sum <= r_sum + r_prod;
            S_SQRT_WAIT: begin
                if (sq_done) r_len <= sq_root;
            end
            S_ROUTE: begin
                if (r_cmd == CMD_ARRIVE) r_m <= {1'b0, r_max_speed};
            end
            S_AR_WAIT: begin
                if (div_done) r_m <= div_q[31:0];
            end
            S_AH_WAIT: begin
                if (div_done) r_m <= (div_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_q[31:0];
            end
            S_PR_ACC: begin
                r_tgt[r_k] <= f_add(r_tgt[r_k], f_signed(r_prod >> FRAC_BITS, r_tv[r_k][31]));
            end
            S_SC_WAIT: begin
                if (div_done) r_d[r_k] <= f_signed(div_q, r_d[r_k][31]);
            end
            S_POST: begin
                // integrate: hand the new velocity to the second limit pass
                r_sum <= '0;
                r_m   <= {1'b0, r_max_speed};
                for (int i = 0; i < 3; i++) r_d[i] <= f_add(r_vel[i], r_d[i]);
            end
            S_OUT: begin
                if (out_go) begin
                    for (int i = 0; i < 3; i++) begin
                        r_o_pos[i] <= r_pos[i];
                        r_o_vel[i] <= r_vel[i];
                        r_o_frc[i] <= r_frc[i];
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_valid       = r_o_valid;
    assign o_out_pos_x   = r_o_pos[0];
    assign o_out_pos_y   = r_o_pos[1];
    assign o_out_pos_z   = r_o_pos[2];
    assign o_out_vel_x   = r_o_vel[0];
    assign o_out_vel_y   = r_o_vel[1];
    assign o_out_vel_z   = r_o_vel[2];
    assign o_out_force_x = r_o_frc[0];
    assign o_out_force_y = r_o_frc[1];
    assign o_out_force_z = r_o_frc[2];

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_AR_WAIT || r_state == S_AH_WAIT || r_state == S_SC_WAIT))
        else $error("divider finished outside a wait state");

    a_sqrt_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_done |-> r_state == S_SQRT_WAIT)
        else $error("root unit finished outside its wait state");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == S_LOAD)
        else $error("accepted word did not start the sequence");

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k != 2'd3)
        else $error("component counter out of range");
endmodule

[src/sa_div.sv]
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
module sa_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quotient
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [63:0] r_quo;
    logic [31:0] r_den;
    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] diff;

    always_comb begin
        rem_sh = {r_rem, r_quo[63]};
        ge     = rem_sh >= {1'b0, r_den};
        diff   = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[31:0] : rem_sh[31:0];
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

[src/sa_isqrt.sv]
// Integer square root of a 64-bit value, two radicand bits a cycle.
module sa_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_value,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_n;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;
    logic [35:0] diff;

    always_comb begin
        rem_sh = {r_rem, r_n[63:62]};
        trial  = {2'b00, r_root, 2'b01};
        ge     = rem_sh >= trial;
        diff   = rem_sh - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_n    <= {r_n[61:0], 2'b00};
            r_rem  <= ge ? diff[33:0] : rem_sh[33:0];
            r_root <= {r_root[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
